/* hdl/fst_pkg.sv */
// Shared types, codes and defaults for the frame sequence timer.
`timescale 1ns / 1ps

package fst_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int TIME_BITS_DEF  = 16;

    localparam int REQ_W   = 3;
    localparam int DELTA_W = 16;
    localparam int SLOT_W  = 4;
    localparam int DUR_W   = 16;
    localparam int POS_W   = 8;
    localparam int INDEX_W = 4;
    localparam int SPEED_W = 12;
    localparam int COUNT_W = 5;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_Q8    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_COUNT = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd256;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 3'd0,
        REQ_LOAD  = 3'd1,
        REQ_PLAY  = 3'd2,
        REQ_PAUSE = 3'd3,
        REQ_STOP  = 3'd4
    } req_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADD   = 6'b000010,
        S_CMP   = 6'b000100,
        S_WAIT  = 6'b001000,
        S_FETCH = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

endpackage

/* hdl/frame_sequence_timer.sv */
// Top level of the frame sequence timer: sequencer, frame tables and shared compare unit.
//
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_type, delta_time, frame_slot,
//                                                frame_duration, frame_col, frame_row
// result    out        result_valid, one cycle   frame_index, cur_col, cur_row,
//                                                is_playing, finished
// config    in         cfg_we                    cfg_addr, cfg_wdata
//
// A tick that runs goes from accept to add and compare, then for each frame it advances
// (at most the frame count) to wait and compare again, then to fetch and result; each
// advance is one table read and one compare and subtract in the shared unit. A tick that
// stops on the last frame goes from compare to fetch. Other items go to fetch and result.
// Reset clears the position, elapsed time and run flag; the frame tables hold garbage until
// loaded. The result cannot be held off; busy stays high until it has been shown.
`timescale 1ns / 1ps

module frame_sequence_timer #(
    parameter int MAX_FRAMES = fst_pkg::MAX_FRAMES_DEF,
    parameter int TIME_BITS  = fst_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [fst_pkg::REQ_W-1:0]       req_type,
    input  logic [fst_pkg::DELTA_W-1:0]     delta_time,
    input  logic [fst_pkg::SLOT_W-1:0]      frame_slot,
    input  logic [fst_pkg::DUR_W-1:0]       frame_duration,
    input  logic [fst_pkg::POS_W-1:0]       frame_col,
    input  logic [fst_pkg::POS_W-1:0]       frame_row,
    output logic                            result_valid,
    output logic [fst_pkg::INDEX_W-1:0]     frame_index,
    output logic [fst_pkg::POS_W-1:0]       cur_col,
    output logic [fst_pkg::POS_W-1:0]       cur_row,
    output logic                            is_playing,
    output logic                            finished,
    input  logic                            cfg_we,
    input  logic [fst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import fst_pkg::*;

    localparam int IW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int EW   = TIME_BITS + 8;
    localparam int PW   = TIME_BITS + SPEED_W;
    localparam int SW   = PW + 1;
    localparam int XW   = (EW > DUR_W + 8) ? EW : DUR_W + 8;

    state_t                 state_reg, state_next;
    logic                   loop_reg, loop_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [EW-1:0]          elapsed_reg, elapsed_next;
    logic [IW-1:0]          cur_reg, cur_next;
    logic                   running_reg, running_next;
    logic                   fin_reg, fin_next;
    logic [CW-1:0]          steps_reg, steps_next;
    logic [PW-1:0]          prod_reg, prod_next;

    logic [DUR_W-1:0]       dur_mem [MAX_FRAMES];
    logic [2*POS_W-1:0]     pos_mem [MAX_FRAMES];
    logic [DUR_W-1:0]       dur_rd_reg;
    logic [2*POS_W-1:0]     pos_rd_reg;

    logic [CW-1:0]          active_n;
    logic [31:0]            delta_ext;
    logic [TIME_BITS-1:0]   delta_eff;
    logic [SW-1:0]          sum;
    logic [XW-1:0]          elapsed_x;
    logic [XW-1:0]          dur_x;
    logic [XW-1:0]          diff_x;
    logic [CW-1:0]          cur_inc;
    logic [31:0]            cur_ext;
    logic                   slot_ok;
    logic                   accept;

    assign accept    = start && (state_reg == S_IDLE);
    assign active_n  = (32'(count_reg) < MAX_FRAMES) ? CW'(count_reg) : CW'(MAX_FRAMES);
    assign delta_ext = 32'(delta_time);
    assign delta_eff = delta_ext[TIME_BITS-1:0];
    assign sum       = SW'(elapsed_reg) + SW'(prod_reg);
    assign elapsed_x = XW'(elapsed_reg);
    assign dur_x     = XW'({dur_rd_reg, 8'd0});
    assign diff_x    = elapsed_x - dur_x;
    assign cur_inc   = CW'(cur_reg) + CW'(1);
    assign slot_ok   = 32'(frame_slot) < MAX_FRAMES;
    assign cur_ext   = 32'(cur_reg);

    always_comb
    begin
        state_next   = state_reg;
        loop_next    = loop_reg;
        speed_next   = speed_reg;
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        cur_next     = cur_reg;
        running_next = running_reg;
        fin_next     = fin_reg;
        steps_next   = steps_reg;
        prod_next    = prod_reg;

        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_LOOP_ENABLE: loop_next  = cfg_wdata[0];
                CFG_SPEED_Q8:    speed_next = cfg_wdata[SPEED_W-1:0];
                CFG_FRAME_COUNT: count_next = cfg_wdata[COUNT_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    fin_next   = 1'b0;
                    state_next = S_FETCH;
                    case (req_type)
                        REQ_TICK:
                        begin
                            if (running_reg && (active_n != '0))
                            begin
                                if (CW'(cur_reg) >= active_n)
                                begin
                                    cur_next = '0;
                                end
                                prod_next  = PW'(delta_eff) * PW'(speed_reg);
                                state_next = S_ADD;
                            end
                        end
                        REQ_PLAY:
                        begin
                            if (active_n != '0)
                            begin
                                running_next = 1'b1;
                            end
                        end
                        REQ_PAUSE:
                        begin
                            running_next = 1'b0;
                        end
                        REQ_STOP:
                        begin
                            running_next = 1'b0;
                            elapsed_next = '0;
                            cur_next     = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ADD:
            begin
                if (sum[SW-1:EW] != '0)
                begin
                    elapsed_next = '1;
                end
                else
                begin
                    elapsed_next = sum[EW-1:0];
                end
                steps_next = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if ((steps_reg == active_n) || (elapsed_x < dur_x))
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    elapsed_next = diff_x[EW-1:0];
                    steps_next   = steps_reg + CW'(1);
                    if (cur_inc >= active_n)
                    begin
                        if (loop_reg)
                        begin
                            cur_next   = '0;
                            state_next = S_WAIT;
                        end
                        else
                        begin
                            cur_next     = IW'(active_n - CW'(1));
                            running_next = 1'b0;
                            fin_next     = 1'b1;
                            state_next   = S_FETCH;
                        end
                    end
                    else
                    begin
                        cur_next   = IW'(cur_inc);
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                state_next = S_CMP;
            end
            S_FETCH:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            loop_reg    <= 1'b1;
            speed_reg   <= SPEED_RESET;
            count_reg   <= '0;
            elapsed_reg <= '0;
            cur_reg     <= '0;
            running_reg <= 1'b0;
            fin_reg     <= 1'b0;
            steps_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            loop_reg    <= loop_next;
            speed_reg   <= speed_next;
            count_reg   <= count_next;
            elapsed_reg <= elapsed_next;
            cur_reg     <= cur_next;
            running_reg <= running_next;
            fin_reg     <= fin_next;
            steps_reg   <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req_type == REQ_LOAD) && slot_ok)
        begin
            dur_mem[IW'(frame_slot)] <= frame_duration;
            pos_mem[IW'(frame_slot)] <= {frame_row, frame_col};
        end
        dur_rd_reg <= dur_mem[cur_reg];
        pos_rd_reg <= pos_mem[cur_reg];
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_RESP);
    assign frame_index  = cur_ext[INDEX_W-1:0];
    assign cur_col      = pos_rd_reg[POS_W-1:0];
    assign cur_row      = pos_rd_reg[2*POS_W-1:POS_W];
    assign is_playing   = running_reg;
    assign finished     = fin_reg;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the frame sequence timer, scoring directed and random requests.
`timescale 1ns / 1ps

module testbench;

    import fst_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 620;
    localparam int PHASE_ITEMS  = 40;
    localparam int MAX_GAP      = 18;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    localparam longint unsigned ELAPSED_LIMIT = (64'd1 << (TIME_BITS_DEF + 8)) - 64'd1;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [DELTA_W-1:0] delta;
        logic [SLOT_W-1:0]  slot;
        logic [DUR_W-1:0]   dur;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
    } frame_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               playing;
        logic               done;
    } frame_view_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [REQ_W-1:0]      req_type = '0;
    logic [DELTA_W-1:0]    delta_time = '0;
    logic [SLOT_W-1:0]     frame_slot = '0;
    logic [DUR_W-1:0]      frame_duration = '0;
    logic [POS_W-1:0]      frame_col = '0;
    logic [POS_W-1:0]      frame_row = '0;
    logic                  result_valid;
    logic [INDEX_W-1:0]    frame_index;
    logic [POS_W-1:0]      cur_col;
    logic [POS_W-1:0]      cur_row;
    logic                  is_playing;
    logic                  finished;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [DUR_W-1:0]   dur_tbl [MAX_FRAMES_DEF];
    logic [POS_W-1:0]   col_tbl [MAX_FRAMES_DEF];
    logic [POS_W-1:0]   row_tbl [MAX_FRAMES_DEF];
    longint unsigned    elapsed_acc = 0;
    int                 frame_pos = 0;
    bit                 run_flag = 1'b0;
    bit                 cfg_loop = 1'b1;
    logic [SPEED_W-1:0] cfg_speed = SPEED_RESET;
    logic [COUNT_W-1:0] cfg_count = '0;

    frame_view_t pending_views [$];
    frame_view_t oldest_view;
    int          error_count = 0;
    int          cycle_count = 0;
    int          played_items = 0;
    bit          steady_run = 1'b0;

    frame_sequence_timer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .delta_time    (delta_time),
        .frame_slot    (frame_slot),
        .frame_duration(frame_duration),
        .frame_col     (frame_col),
        .frame_row     (frame_row),
        .result_valid  (result_valid),
        .frame_index   (frame_index),
        .cur_col       (cur_col),
        .cur_row       (cur_row),
        .is_playing    (is_playing),
        .finished      (finished),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("frame_sequence_timer regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_views.size() == 0)
            begin
                $error("result with no item outstanding: frame_index %0d", frame_index);
                error_count++;
            end
            else
            begin
                oldest_view = pending_views.pop_front();
                if (frame_index !== oldest_view.index)
                begin
                    $error("frame_index expected %0d got %0d", oldest_view.index, frame_index);
                    error_count++;
                end
                if (cur_col !== oldest_view.col)
                begin
                    $error("cur_col expected %0d got %0d", oldest_view.col, cur_col);
                    error_count++;
                end
                if (cur_row !== oldest_view.row)
                begin
                    $error("cur_row expected %0d got %0d", oldest_view.row, cur_row);
                    error_count++;
                end
                if (is_playing !== oldest_view.playing)
                begin
                    $error("is_playing expected %0d got %0d", oldest_view.playing, is_playing);
                    error_count++;
                end
                if (finished !== oldest_view.done)
                begin
                    $error("finished expected %0d got %0d", oldest_view.done, finished);
                    error_count++;
                end
            end
        end
    end

    function automatic frame_view_t predict_frame_view(input frame_req_t rq);
        frame_view_t     view;
        int              active;
        int              steps;
        longint unsigned total;
        longint unsigned span;
        logic            completed;
        completed = 1'b0;
        active = (int'(cfg_count) < MAX_FRAMES_DEF) ? int'(cfg_count) : MAX_FRAMES_DEF;
        case (rq.req)
            REQ_TICK:
            begin
                if (run_flag && active != 0)
                begin
                    if (frame_pos >= active)
                        frame_pos = 0;
                    total = elapsed_acc + 64'(rq.delta) * 64'(cfg_speed);
                    elapsed_acc = (total > ELAPSED_LIMIT) ? ELAPSED_LIMIT : total;
                    steps = 0;
                    while (steps < active)
                    begin
                        span = 64'(dur_tbl[frame_pos]) << 8;
                        if (elapsed_acc < span)
                            break;
                        elapsed_acc -= span;
                        frame_pos++;
                        steps++;
                        if (frame_pos >= active)
                        begin
                            if (cfg_loop)
                                frame_pos = 0;
                            else
                            begin
                                frame_pos = active - 1;
                                run_flag = 1'b0;
                                completed = 1'b1;
                                break;
                            end
                        end
                    end
                end
            end
            REQ_LOAD:
            begin
                dur_tbl[rq.slot] = rq.dur;
                col_tbl[rq.slot] = rq.col;
                row_tbl[rq.slot] = rq.row;
            end
            REQ_PLAY:
            begin
                if (active != 0)
                    run_flag = 1'b1;
            end
            REQ_PAUSE:
                run_flag = 1'b0;
            REQ_STOP:
            begin
                run_flag = 1'b0;
                elapsed_acc = 0;
                frame_pos = 0;
            end
            default:
            begin
            end
        endcase
        view.index = INDEX_W'(frame_pos);
        view.col = col_tbl[frame_pos];
        view.row = row_tbl[frame_pos];
        view.playing = run_flag;
        view.done = completed;
        return view;
    endfunction

    function automatic frame_req_t make_req(input logic [REQ_W-1:0] req,
                                            input logic [DELTA_W-1:0] delta,
                                            input int slot, input logic [DUR_W-1:0] dur,
                                            input int col, input int row);
        frame_req_t rq;
        rq.req = req;
        rq.delta = delta;
        rq.slot = SLOT_W'(slot);
        rq.dur = dur;
        rq.col = POS_W'(col);
        rq.row = POS_W'(row);
        return rq;
    endfunction

    function automatic int idle_gap();
        return steady_run ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic issue_request(input frame_req_t rq, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        {req_type, delta_time, frame_slot, frame_duration, frame_col, frame_row} <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        played_items++;
        pending_views.insert(pending_views.size(), predict_frame_view(rq));
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (pending_views.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_settings(input bit loop_on, input logic [SPEED_W-1:0] speed,
                                  input logic [COUNT_W-1:0] count);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_LOOP_ENABLE;
        cfg_wdata <= CFG_DATA_W'(loop_on);
        @(posedge clk);
        cfg_loop = loop_on;
        cfg_addr <= CFG_SPEED_Q8;
        cfg_wdata <= CFG_DATA_W'(speed);
        @(posedge clk);
        cfg_speed = speed;
        cfg_addr <= CFG_FRAME_COUNT;
        cfg_wdata <= CFG_DATA_W'(count);
        @(posedge clk);
        cfg_count = count;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Slot 0 goes first so that the frame shown after the first item is always loaded.
    task automatic test_table_load();
        int               slot;
        logic [DUR_W-1:0] dur;
        for (slot = 0; slot < MAX_FRAMES_DEF; slot++)
        begin
            dur = (slot == 3) ? '0 : (slot == 15) ? '1 : DUR_W'(slot + 1);
            issue_request(make_req(REQ_LOAD, DELTA_W'($urandom), slot, dur,
                                   slot * 17, 255 - slot * 17), idle_gap());
        end
    endtask

    task automatic test_idle_requests();
        issue_request(make_req(REQ_PLAY, '0, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_TICK, '1, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_UNUSED_LO, '1, 5, '1, 255, 255), idle_gap());
        issue_request(make_req(REQ_UNUSED_HI, 16'd7, 9, '1, 1, 2), idle_gap());
    endtask

    task automatic test_directed_playback();
        hold_until_drained();
        apply_settings(1'b1, SPEED_RESET, 5'd16);
        issue_request(make_req(REQ_PLAY, '0, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_TICK, 16'd5, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_TICK, 16'd10, 0, '0, 0, 0), idle_gap());
        // The frame reached above lies past the new count, and the tick saturates.
        hold_until_drained();
        apply_settings(1'b0, 12'd4095, 5'd3);
        issue_request(make_req(REQ_TICK, '1, 0, '0, 0, 0), idle_gap());
        hold_until_drained();
        apply_settings(1'b1, 12'd4095, 5'd4);
        issue_request(make_req(REQ_PLAY, '0, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_TICK, '1, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_PAUSE, '0, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_TICK, 16'd1, 0, '0, 0, 0), idle_gap());
        issue_request(make_req(REQ_STOP, '0, 0, '0, 0, 0), idle_gap());
    endtask

    task automatic test_random_playback();
        int         phase;
        int         k;
        int         r;
        frame_req_t rq;
        phase = 0;
        while (played_items < RANDOM_ITEMS)
        begin
            hold_until_drained();
            case (phase)
                0: apply_settings(1'b1, 12'd0, 5'd16);
                1: apply_settings(1'b0, 12'd4095, 5'd1);
                2: apply_settings(1'b1, 12'd4095, 5'd16);
                3: apply_settings(1'b0, SPEED_RESET, 5'd16);
                4: apply_settings(1'b1, 12'd1, 5'd0);
                default: apply_settings(1'($urandom_range(0, 1)),
                                        ($urandom_range(0, 3) == 0) ?
                                            SPEED_W'($urandom) :
                                            SPEED_W'($urandom_range(64, 512)),
                                        COUNT_W'($urandom_range(0, 16)));
            endcase
            phase++;
            steady_run = ($urandom_range(0, 3) == 0);
            issue_request(make_req(REQ_PLAY, DELTA_W'($urandom), 0, DUR_W'($urandom), 0, 0),
                          idle_gap());
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                rq = make_req(REQ_TICK, '0, $urandom_range(0, 15), '0,
                              $urandom_range(0, 255), $urandom_range(0, 255));
                r = $urandom_range(0, 19);
                rq.delta = (r == 0) ? '0 : (r == 1) ? '1 :
                           (r < 14) ? DELTA_W'($urandom_range(0, 63)) :
                           (r < 18) ? DELTA_W'($urandom_range(0, 4095)) : DELTA_W'($urandom);
                r = $urandom_range(0, 19);
                rq.dur = (r < 4) ? '0 : (r == 4) ? '1 :
                         (r < 16) ? DUR_W'($urandom_range(0, 63)) :
                         (r < 19) ? DUR_W'($urandom_range(0, 1023)) : DUR_W'($urandom);
                r = $urandom_range(0, 99);
                if (r >= 97)
                    rq.req = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                else if (r >= 91)
                    rq.req = REQ_STOP;
                else if (r >= 85)
                    rq.req = REQ_PAUSE;
                else if (r >= 73)
                    rq.req = REQ_PLAY;
                else if (r >= 60)
                    rq.req = REQ_LOAD;
                issue_request(rq, idle_gap());
                if ($urandom_range(0, 49) == 0)
                    hold_until_drained();
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_idle_requests();
        test_directed_playback();
        test_random_playback();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_views.size() == 0)
            $display("frame_sequence_timer regression: pass");
        else
            $display("frame_sequence_timer regression: fail");
        $finish;
    end

endmodule
